FILE: design/assert_macros.svh
// Assertion macros used by the list engine top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the trigger.
`define PALE_ASSERT_SAME(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
      else $error("list engine check failed in the same cycle");

// Check that the consequent holds in the cycle after the trigger.
`define PALE_ASSERT_NEXT(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("list engine check failed one cycle later");

`endif

FILE: design/pale_pkg.sv
// Types, codes and widths shared by the list engine modules.
package pale_pkg;

   localparam int DEPTH_DEF = 64;
   localparam int ELEM_W    = 32;
   localparam int POS_W     = 7;
   localparam int IDX_W     = 6;
   localparam int LEN_W     = 7;
   localparam int OP_W      = 3;

   // Opcodes carried on the input tuser.
   localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
   localparam logic [OP_W-1:0] OP_DISPLAY = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT  = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE  = 3'd3;
   localparam logic [OP_W-1:0] OP_SEARCH  = 3'd4;

   // Result status codes.
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_MISS  = 2'd2,
      STAT_EMPTY = 2'd3
   } status_type;

   // Action broadcast to every cell of the chain.
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [POS_W-1:0]  pos0;   // zero-based target position
      logic [LEN_W-1:0]  len;    // current list length
      logic [ELEM_W-1:0] value;  // data to write, or search key
   } cell_ctl_type;

endpackage

FILE: design/positional_array_list_engine.sv
// Top level of the positional list engine: command decode, cell chain and result register.
`include "assert_macros.svh"

// Positional list engine. Holds an ordered list of up to DEPTH signed 32-bit
// elements in a chain of cells, one element per cell, plus the list length.
// Input items carry an opcode on req_tuser (create, display, insert, delete,
// search) and a 1-based position and a value on req_tdata. Create, insert and
// delete move every affected cell at once; their single result is ready in the
// next cycle, and a new item is taken as soon as the result register is free
// or being drained. Search first has the cells compare the key in parallel,
// then the first match is encoded. Display starts a run that emits the head
// element and rotates the chain by one cell per result; it is paced by the
// single result register, so a stalled rsp_tready stretches it. No clearing
// pass is needed after reset. Bad positions, a full list and unknown opcodes
// leave the list unchanged and report status 1; a delete on an empty list
// reports status 3.
module positional_array_list_engine #(
   parameter int DEPTH = pale_pkg::DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Input item channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // position [6:0], value [38:7], zero pad
   input  logic [2:0]  req_tuser,   // opcode [2:0]
   // Result item channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // element [31:0], index [37:32], length [44:38], pad
   output logic [1:0]  rsp_tuser,   // status [1:0]
   output logic        rsp_tlast
);

   localparam int EW = pale_pkg::ELEM_W;
   localparam int PW = pale_pkg::POS_W;
   localparam int IW = pale_pkg::IDX_W;
   localparam int LW = pale_pkg::LEN_W;
   localparam logic [LW:0] DEPTH_W = (LW+1)'(DEPTH);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_DISPLAY
   } state_type;

   state_type            state_ff, state_in;
   logic [LW-1:0]        len_ff, len_in;
   logic [IW-1:0]        cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   pale_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [EW-1:0]        rsp_elem_ff, rsp_elem_in;
   logic [IW-1:0]        rsp_index_ff, rsp_index_in;
   logic [LW-1:0]        rsp_len_ff, rsp_len_in;
   logic                 rsp_last_ff, rsp_last_in;

   pale_pkg::cell_ctl_type ctl;
   logic [EW-1:0]          cell_data [DEPTH];
   logic [DEPTH-1:0]       match_vec;
   logic [DEPTH-1:0]       first_hot;
   logic [IW-1:0]          first_idx;
   logic                   found;

   logic              accept;
   logic              slot_free;
   logic [2:0]        opcode;
   logic [PW-1:0]     position;
   logic [EW-1:0]     value;
   logic [LW:0]       len_ext;
   logic [LW:0]       pos_ext;
   logic              disp_last;

   // Unpack the input item
   assign opcode   = req_tuser;
   assign position = req_tdata[PW-1:0];
   assign value    = req_tdata[PW+EW-1:PW];
   assign len_ext  = {1'b0, len_ff};
   assign pos_ext  = {1'b0, position};

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign disp_last  = ((LW'(cnt_ff) + LW'(1)) == len_ff);

   // Chain of cells
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [EW-1:0] left_d, right_d;
      if (g == 0) begin : g_first
         assign left_d = ctl.value;
      end else begin : g_mid
         assign left_d = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_end
         assign right_d = cell_data[g];
      end else begin : g_inner
         assign right_d = cell_data[g+1];
      end
      pale_cell #(.IDX(g)) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .left_data  (left_d),
         .right_data (right_d),
         .head_data  (cell_data[0]),
         .data       (cell_data[g]),
         .match      (match_vec[g])
      );
   end

   // Isolate the lowest match and encode its index
   assign first_hot = match_vec & (~match_vec + DEPTH'(1));
   assign found     = |match_vec;
   always_comb begin
      first_idx = '0;
      for (int b = 0; b < IW; b++) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (first_hot[i] && (((i >> b) & 1) != 0)) first_idx[b] = 1'b1;
         end
      end
   end

   // Decode commands, drive the chain and build results
   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_elem_in   = rsp_elem_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_last_in   = rsp_last_ff;
      ctl.op        = pale_pkg::CELL_HOLD;
      ctl.pos0      = position - PW'(1);
      ctl.len       = len_ff;
      ctl.value     = value;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pale_pkg::STAT_OK;
               rsp_elem_in   = '0;
               rsp_index_in  = '0;
               rsp_last_in   = 1'b1;
               unique case (opcode)
                  pale_pkg::OP_CREATE: begin
                     if (position != '0 && pos_ext <= len_ext + 1'b1
                         && pos_ext <= DEPTH_W) begin
                        ctl.op = pale_pkg::CELL_WRITE;
                        len_in = position;
                     end else begin
                        rsp_status_in = pale_pkg::STAT_RANGE;
                     end
                  end
                  pale_pkg::OP_DISPLAY: begin
                     if (len_ff == '0) begin
                        rsp_status_in = pale_pkg::STAT_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        cnt_in       = '0;
                        state_in     = S_DISPLAY;
                     end
                  end
                  pale_pkg::OP_INSERT: begin
                     if (len_ext < DEPTH_W && position != '0
                         && pos_ext <= len_ext + 1'b1) begin
                        ctl.op = pale_pkg::CELL_INSERT;
                        len_in = len_ff + LW'(1);
                     end else begin
                        rsp_status_in = pale_pkg::STAT_RANGE;
                     end
                  end
                  pale_pkg::OP_DELETE: begin
                     if (len_ff == '0) begin
                        rsp_status_in = pale_pkg::STAT_EMPTY;
                     end else if (position != '0 && position <= len_ff) begin
                        ctl.op = pale_pkg::CELL_DELETE;
                        len_in = len_ff - LW'(1);
                     end else begin
                        rsp_status_in = pale_pkg::STAT_RANGE;
                     end
                  end
                  pale_pkg::OP_SEARCH: begin
                     if (len_ff == '0) begin
                        rsp_status_in = pale_pkg::STAT_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_SEARCH;
                     end
                  end
                  default: rsp_status_in = pale_pkg::STAT_RANGE;
               endcase
               rsp_len_in = len_in;
            end
         end
         S_SEARCH: begin
            // Cells registered their compare on the accept cycle
            rsp_valid_in  = 1'b1;
            rsp_status_in = found ? pale_pkg::STAT_OK : pale_pkg::STAT_MISS;
            rsp_elem_in   = '0;
            rsp_index_in  = found ? first_idx : '0;
            rsp_len_in    = len_ff;
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
         end
         S_DISPLAY: begin
            // Emit the head and rotate the list by one cell
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pale_pkg::STAT_OK;
               rsp_elem_in   = cell_data[0];
               rsp_index_in  = cnt_ff;
               rsp_len_in    = len_ff;
               rsp_last_in   = disp_last;
               ctl.op        = pale_pkg::CELL_ROTATE;
               cnt_in        = cnt_ff + IW'(1);
               if (disp_last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff        <= cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_elem_ff   <= rsp_elem_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_len_ff, rsp_index_ff, rsp_elem_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Length never exceeds the chain
   `PALE_ASSERT_SAME(a_len_bound, clock, reset, 1'b1, {1'b0, len_ff} <= DEPTH_W)
   // Length moves only when an item is taken
   `PALE_ASSERT_NEXT(a_len_stable, clock, reset, !accept, $stable(len_ff))
   // A search answers in the following cycle
   `PALE_ASSERT_NEXT(a_search_done, clock, reset, state_ff == S_SEARCH,
                     rsp_tvalid && rsp_tlast && state_ff == S_IDLE)
   // The final display step ends the run with a marked result
   `PALE_ASSERT_NEXT(a_display_end, clock, reset,
                     state_ff == S_DISPLAY && slot_free && disp_last,
                     rsp_tvalid && rsp_tlast && state_ff == S_IDLE)

endmodule

FILE: design/pale_cell.sv
// One cell of the list chain: holds one element and compares it with the key.
module pale_cell #(
   parameter int IDX = 0
) (
   input  logic                          clock,
   input  pale_pkg::cell_ctl_type        ctl,
   input  logic [pale_pkg::ELEM_W-1:0]   left_data,
   input  logic [pale_pkg::ELEM_W-1:0]   right_data,
   input  logic [pale_pkg::ELEM_W-1:0]   head_data,
   output logic [pale_pkg::ELEM_W-1:0]   data,
   output logic                          match
);

   localparam logic [pale_pkg::LEN_W-1:0] IDX_L  = pale_pkg::LEN_W'(IDX);
   localparam logic [pale_pkg::LEN_W-1:0] NEXT_L = pale_pkg::LEN_W'(IDX + 1);

   logic [pale_pkg::ELEM_W-1:0] data_ff, data_in;
   logic                        match_ff, match_in;

   // Pick the next element from the broadcast action and the neighbors
   always_comb begin
      data_in = data_ff;
      unique case (ctl.op)
         pale_pkg::CELL_WRITE: begin
            if (IDX_L == ctl.pos0) data_in = ctl.value;
         end
         pale_pkg::CELL_INSERT: begin
            if (IDX_L == ctl.pos0) data_in = ctl.value;
            else if (IDX_L > ctl.pos0) data_in = left_data;
         end
         pale_pkg::CELL_DELETE: begin
            if (IDX_L >= ctl.pos0 && NEXT_L < ctl.len) data_in = right_data;
         end
         pale_pkg::CELL_ROTATE: begin
            if (NEXT_L < ctl.len) data_in = right_data;
            else if (NEXT_L == ctl.len) data_in = head_data;
         end
         default: data_in = data_ff;
      endcase
      // Compare only entries that lie inside the list
      match_in = (data_ff == ctl.value) && (IDX_L < ctl.len);
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule

FILE: sim/positional_array_list_engine_tb.sv
// Self-checking testbench for the positional list engine: directed and random item streams.
`timescale 1ns / 100ps

module positional_array_list_engine_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 200;
   localparam int LIST_DEPTH  = pale_pkg::DEPTH_DEF;
   // Opcodes the block has no use for
   localparam logic [pale_pkg::OP_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [pale_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

   typedef struct {
      pale_pkg::status_type          status;
      logic [pale_pkg::ELEM_W-1:0]   element;
      logic [pale_pkg::IDX_W-1:0]    index;
      logic [pale_pkg::LEN_W-1:0]    length;
      logic                          last;
   } list_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // position [6:0], value [38:7], zero pad
   logic [2:0]  req_tuser  = '0;   // opcode [2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // element [31:0], index [37:32], length [44:38], pad
   logic [1:0]  rsp_tuser;         // status [1:0]
   logic        rsp_tlast;

   // Shadow copy of the list and the results it predicts
   logic [pale_pkg::ELEM_W-1:0] shadow_list [LIST_DEPTH];
   int                          shadow_len;
   list_result_type             pending_results [$];

   int error_count = 0;
   int cycle_count = 0;
   int hold_cycles = 0;
   bit no_idle     = 1'b0;

   positional_array_list_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Apply one accepted item to the shadow list and queue its results
   task automatic predict_list_op(input logic [pale_pkg::OP_W-1:0] op,
                                  input logic [pale_pkg::POS_W-1:0] pos,
                                  input logic [pale_pkg::ELEM_W-1:0] val);
      int              n;
      int              p;
      list_result_type r;
      n = shadow_len;
      p = int'(pos);
      r.status  = pale_pkg::STAT_OK;
      r.element = '0;
      r.index   = '0;
      r.length  = '0;
      r.last    = 1'b1;
      if (op == pale_pkg::OP_DISPLAY && n > 0) begin
         // One result per element, last on the final one
         for (int j = 0; j < n; j++) begin
            r.element = shadow_list[j];
            r.index   = pale_pkg::IDX_W'(j);
            r.length  = pale_pkg::LEN_W'(n);
            r.last    = (j == n - 1);
            pending_results.push_back(r);
         end
      end else begin
         case (op)
            pale_pkg::OP_CREATE: begin
               if (p < 1 || p > n + 1 || p > LIST_DEPTH) begin
                  r.status = pale_pkg::STAT_RANGE;
               end else begin
                  shadow_list[p-1] = val;
                  shadow_len       = p;
               end
            end
            pale_pkg::OP_DISPLAY: begin
               r.status = pale_pkg::STAT_EMPTY;
            end
            pale_pkg::OP_INSERT: begin
               if (n >= LIST_DEPTH || p < 1 || p > n + 1) begin
                  r.status = pale_pkg::STAT_RANGE;
               end else begin
                  for (int j = n; j > p - 1; j--) shadow_list[j] = shadow_list[j-1];
                  shadow_list[p-1] = val;
                  shadow_len       = n + 1;
               end
            end
            pale_pkg::OP_DELETE: begin
               if (n == 0) begin
                  r.status = pale_pkg::STAT_EMPTY;
               end else if (p < 1 || p > n) begin
                  r.status = pale_pkg::STAT_RANGE;
               end else begin
                  for (int j = p - 1; j + 1 < n; j++) shadow_list[j] = shadow_list[j+1];
                  shadow_len = n - 1;
               end
            end
            pale_pkg::OP_SEARCH: begin
               if (n == 0) begin
                  r.status = pale_pkg::STAT_EMPTY;
               end else begin
                  r.status = pale_pkg::STAT_MISS;
                  for (int j = n - 1; j >= 0; j--) begin
                     if (shadow_list[j] == val) begin
                        r.status = pale_pkg::STAT_OK;
                        r.index  = pale_pkg::IDX_W'(j);
                     end
                  end
               end
            end
            default: begin
               r.status = pale_pkg::STAT_RANGE;
            end
         endcase
         r.length = pale_pkg::LEN_W'(shadow_len);
         pending_results.push_back(r);
      end
   endtask

   // Offer one item after a random gap, hold it until taken, then predict
   task automatic send_item(input logic [pale_pkg::OP_W-1:0] op,
                            input logic [pale_pkg::POS_W-1:0] pos,
                            input logic [pale_pkg::ELEM_W-1:0] val);
      int gap;
      gap = no_idle ? 0 : int'($urandom_range(3));
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, val, pos};
      do @(posedge clock); while (!req_tready);
      predict_list_op(op, pos, val);
   endtask

   // Drop valid and wait for every outstanding result
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Extremes, small values that repeat, and full-range noise
   function automatic logic [pale_pkg::ELEM_W-1:0] pick_value();
      case ($urandom_range(7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2, 3:    return $urandom_range(7);
         default: return $urandom;
      endcase
   endfunction

   // Draw one item: mostly legal edits on the current list, some garbage
   task automatic send_random_op();
      int n;
      int sel;
      n   = shadow_len;
      sel = int'($urandom_range(99));
      if (sel < 12) begin
         send_item(pale_pkg::OP_W'($urandom_range(OP_SPARE_HI)),
                   pale_pkg::POS_W'($urandom_range(127)), $urandom);
      end else if (sel < 40 && n < LIST_DEPTH) begin
         send_item(pale_pkg::OP_CREATE,
                   pale_pkg::POS_W'(($urandom_range(3) != 0) ? n + 1
                                                             : $urandom_range(1, n + 1)),
                   pick_value());
      end else if (sel < 58 && n < LIST_DEPTH) begin
         send_item(pale_pkg::OP_INSERT, pale_pkg::POS_W'($urandom_range(1, n + 1)),
                   pick_value());
      end else if (sel < 76 && n > 0) begin
         send_item(pale_pkg::OP_DELETE, pale_pkg::POS_W'($urandom_range(1, n)),
                   pick_value());
      end else if (sel < 93) begin
         send_item(pale_pkg::OP_SEARCH, pale_pkg::POS_W'($urandom_range(127)),
                   (n > 0 && $urandom_range(2) != 0) ? shadow_list[$urandom_range(n - 1)]
                                                     : pick_value());
      end else begin
         send_item(pale_pkg::OP_DISPLAY, pale_pkg::POS_W'($urandom_range(127)), $urandom);
      end
   endtask

   // Each of the five commands against an empty list
   task automatic test_empty_list();
      send_item(pale_pkg::OP_DISPLAY, 7'd0, 32'd0);
      send_item(pale_pkg::OP_SEARCH, 7'd0, 32'd0);
      send_item(pale_pkg::OP_DELETE, 7'd1, 32'd0);
      send_item(pale_pkg::OP_INSERT, 7'd2, 32'd5);
      send_item(pale_pkg::OP_CREATE, 7'd0, 32'd5);
      send_item(pale_pkg::OP_CREATE, 7'd2, 32'd5);
   endtask

   // Build a short list and edit both ends, including bad positions
   task automatic test_basic_edits();
      send_item(pale_pkg::OP_CREATE, 7'd1, 32'h8000_0000);
      send_item(pale_pkg::OP_CREATE, 7'd2, 32'h7FFF_FFFF);
      send_item(pale_pkg::OP_INSERT, 7'd1, 32'hFFFF_FFFF);
      send_item(pale_pkg::OP_INSERT, 7'd4, 32'h0000_0000);
      send_item(pale_pkg::OP_INSERT, 7'd127, 32'd1);
      send_item(pale_pkg::OP_DELETE, 7'd0, 32'd0);
      send_item(pale_pkg::OP_DELETE, 7'd5, 32'd0);
      send_item(pale_pkg::OP_SEARCH, 7'd0, 32'h7FFF_FFFF);
      send_item(pale_pkg::OP_SEARCH, 7'd0, 32'd12345);
      send_item(pale_pkg::OP_DISPLAY, 7'd0, 32'd0);
      send_item(pale_pkg::OP_DELETE, 7'd4, 32'd0);
      send_item(pale_pkg::OP_DELETE, 7'd1, 32'd0);
      send_item(pale_pkg::OP_CREATE, 7'd1, 32'd9);
      send_item(pale_pkg::OP_DISPLAY, 7'd0, 32'd0);
   endtask

   // Unused opcodes leave the list alone
   task automatic test_spare_opcodes();
      for (int op = int'(OP_SPARE_LO); op <= int'(OP_SPARE_HI); op++) begin
         send_item(pale_pkg::OP_W'(op), 7'd1, 32'hA5A5_A5A5);
      end
      send_item(pale_pkg::OP_DISPLAY, 7'd0, 32'd0);
   endtask

   // Hold the result side for a long stretch while items keep coming
   task automatic test_output_stall();
      wait_drained();
      hold_cycles = LONG_HOLD;
      for (int k = 0; k < 8; k++) begin
         send_item(k[0] ? pale_pkg::OP_SEARCH : pale_pkg::OP_INSERT, 7'd1, pick_value());
      end
      send_item(pale_pkg::OP_DISPLAY, 7'd0, 32'd0);
      wait_drained();
   endtask

   // Fill to capacity, then push against every full-list edge
   task automatic test_full_list();
      while (shadow_len < LIST_DEPTH) begin
         send_item(pale_pkg::OP_CREATE, pale_pkg::POS_W'(shadow_len + 1), pick_value());
      end
      send_item(pale_pkg::OP_INSERT, 7'd1, 32'd1);
      send_item(pale_pkg::OP_CREATE, pale_pkg::POS_W'(LIST_DEPTH + 1), 32'd1);
      send_item(pale_pkg::OP_CREATE, pale_pkg::POS_W'(LIST_DEPTH), 32'h7FFF_FFFF);
      send_item(pale_pkg::OP_SEARCH, 7'd0, 32'h7FFF_FFFF);
      send_item(pale_pkg::OP_DISPLAY, 7'd0, 32'd0);
      send_item(pale_pkg::OP_DELETE, pale_pkg::POS_W'(LIST_DEPTH + 1), 32'd0);
      send_item(pale_pkg::OP_DELETE, pale_pkg::POS_W'(LIST_DEPTH), 32'd0);
      send_item(pale_pkg::OP_INSERT, pale_pkg::POS_W'(LIST_DEPTH), 32'h8000_0000);
      send_item(pale_pkg::OP_DELETE, 7'd1, 32'd0);
      send_item(pale_pkg::OP_DISPLAY, 7'd0, 32'd0);
   endtask

   // Random walk over the list, with stretches of no idling
   task automatic test_random_ops();
      for (int k = 0; k < 150; k++) begin
         no_idle = ((k / 40) % 2) == 1;
         send_random_op();
      end
      no_idle = 1'b0;
   endtask

   // Compare one field and report a mismatch
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Check every accepted result against the oldest prediction
   always @(posedge clock) begin : result_check
      list_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, got status %0d element %0h",
                     $time, rsp_tuser, rsp_tdata[31:0]);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_tuser));
            check_field("element", want.element, rsp_tdata[31:0]);
            check_field("index", 32'(want.index), 32'(rsp_tdata[37:32]));
            check_field("length", 32'(want.length), 32'(rsp_tdata[44:38]));
            check_field("last", 32'(want.last), 32'(rsp_tlast));
         end
      end
   end

   // Result side: random stalls per item, plus a long hold on request
   initial begin : result_drain
      int gap;
      forever begin
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         gap = no_idle ? 0 : int'($urandom_range(3));
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready) && hold_cycles == 0);
      end
   end

   // End the run if it hangs
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** positional_array_list_engine: FAILED **");
      $finish;
   end

   initial begin : main_sequence
      for (int j = 0; j < LIST_DEPTH; j++) shadow_list[j] = '0;
      shadow_len = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_basic_edits();
      test_spare_opcodes();
      test_output_stall();
      test_full_list();
      test_random_ops();
      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("** positional_array_list_engine: PASSED **");
      end else begin
         $display("** positional_array_list_engine: FAILED **");
      end
      $finish;
   end

endmodule
